// ----- design/pn_pkg.sv -----
package pn_pkg;

	// path bytes
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// role of the string being received
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LONE = 2'd1;
	localparam logic [1:0] PH_BASE = 2'd2;
	localparam logic [1:0] PH_REL  = 2'd3;

	// op codes of the first item of a job
	localparam logic [1:0] OP_LONE = 2'd0;
	localparam logic [1:0] OP_BASE = 2'd1;

	typedef struct packed {
		logic take;
		logic pop_rd;
		logic pop_chk;
		logic emit_rd;
		logic emit_ld;
	} pn_cmd_t;

	typedef struct packed {
		logic pop_req;
		logic emit_req;
		logic pop_end;
		logic pop_hit;
		logic out_free;
		logic reject;
		logic last_byte;
	} pn_stat_t;

endpackage

// ----- design/pn_ctrl.sv -----
module pn_ctrl import pn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pn_stat_t st,
	output pn_cmd_t  cmd
);

	localparam logic [2:0] S_RUN     = 3'd0;
	localparam logic [2:0] S_POP_RD  = 3'd1;
	localparam logic [2:0] S_POP_CHK = 3'd2;
	localparam logic [2:0] S_EMIT_RD = 3'd3;
	localparam logic [2:0] S_EMIT_LD = 3'd4;

	logic [2:0] state_q, state_d;
	logic       eos_pend_q, eos_pend_d;

	assign in_ready = (state_q == S_RUN);

	always_comb begin
		state_d    = state_q;
		eos_pend_d = eos_pend_q;
		cmd        = '0;
		unique case (state_q)
			S_RUN: begin
				cmd.take = in_valid;
				if (in_valid) begin
					if (st.pop_req) begin
						state_d    = S_POP_RD;
						eos_pend_d = st.emit_req;
					end else if (st.emit_req) begin
						state_d = S_EMIT_RD;
					end
				end
			end
			S_POP_RD: begin
				cmd.pop_rd = 1'b1;
				if (st.pop_end)
					state_d = eos_pend_q ? S_EMIT_RD : S_RUN;
				else
					state_d = S_POP_CHK;
			end
			S_POP_CHK: begin
				cmd.pop_chk = 1'b1;
				if (st.pop_hit)
					state_d = eos_pend_q ? S_EMIT_RD : S_RUN;
				else
					state_d = S_POP_RD;
			end
			S_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				if (st.out_free)
					state_d = st.reject ? S_RUN : S_EMIT_LD;
			end
			S_EMIT_LD: begin
				cmd.emit_ld = 1'b1;
				state_d = st.last_byte ? S_RUN : S_EMIT_RD;
			end
			default: state_d = S_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_RUN;
			eos_pend_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			eos_pend_q <= eos_pend_d;
		end
	end

endmodule

// ----- design/pn_datapath.sv -----
module pn_datapath import pn_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  pn_cmd_t    cmd,
	output pn_stat_t   st,
	input  logic [1:0] op,
	input  logic [7:0] char_in,
	input  logic       no_char,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       status,
	output logic [7:0] char_out,
	output logic       final_res
);

	localparam int LW = $clog2(CAPACITY + 2);
	localparam int AW = $clog2(CAPACITY);
	localparam int PW = LW + 1;
	localparam logic [LW-1:0] CAP_L  = LW'(CAPACITY);
	localparam logic [LW-1:0] CAP1_L = LW'(CAPACITY + 1);
	localparam logic [PW-1:0] CAP_P  = PW'(CAPACITY);

	logic [7:0]    mem [CAPACITY];
	logic [7:0]    rdata_q;
	logic [1:0]    jphase_q;
	logic [LW-1:0] len_q, seglen_q, pop_ptr_q;
	logic          fail_q, nul_q, fresh_q, root_q, dot0_q, dot1_q;
	logic [AW-1:0] e_idx_q;
	logic          ovalid_q, ostat_q, olast_q;
	logic [7:0]    ochar_q;

	// next-state values of one accepted item
	logic [1:0]    ph;
	logic [LW-1:0] l, sl;
	logic          f, nf, fr, rt, d0, d1, sep, fin, sneed, poprq, emrq, we;
	logic [PW-1:0] pos, need;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;

	always_comb begin
		if (jphase_q == PH_IDLE) begin
			ph = (op == OP_LONE) ? PH_LONE : (op == OP_BASE) ? PH_BASE : PH_REL;
			l  = '0;
			f  = 1'b0;
			sl = '0;
			nf = 1'b0;
			fr = 1'b1;
			rt = 1'b0;
		end else begin
			ph = jphase_q;
			l  = len_q;
			f  = fail_q;
			sl = seglen_q;
			nf = nul_q;
			fr = fresh_q;
			rt = root_q;
		end
		d0    = dot0_q;
		d1    = dot1_q;
		sep   = 1'b0;
		fin   = 1'b0;
		poprq = 1'b0;
		emrq  = 1'b0;
		we    = 1'b0;
		waddr = '0;
		wdata = CH_SLASH;
		sneed = 1'b0;
		pos   = '0;
		need  = '0;
		if (!no_char) begin
			sep = (char_in == CH_SLASH) || (char_in == CH_BSLASH);
			if (fr) begin
				fr = 1'b0;
				if (sep) begin
					// root mark
					we = 1'b1;
					l  = LW'(1);
					rt = 1'b1;
					if (ph == PH_REL)
						f = 1'b0;
				end
			end
			if (ph != PH_BASE && char_in == CH_NUL)
				f = 1'b1;
			if (sep) begin
				if (ph == PH_BASE && nf)
					f = 1'b1;
				fin = 1'b1;
			end else begin
				if (char_in == CH_NUL)
					nf = 1'b1;
				// byte goes straight to its place after the kept part
				sneed = (l != '0) && !(l == LW'(1) && rt);
				pos   = PW'(l) + PW'(sneed) + PW'(sl);
				if (pos < CAP_P) begin
					we    = 1'b1;
					waddr = pos[AW-1:0];
					wdata = char_in;
				end
				if (sl == '0)
					d0 = (char_in == CH_DOT);
				if (sl == LW'(1))
					d1 = (char_in == CH_DOT);
				sl = (sl < CAP_L) ? sl + LW'(1) : CAP1_L;
			end
		end
		if (end_of_string && ph != PH_BASE && !sep)
			fin = 1'b1;
		if (fin && !f && sl != '0) begin
			if (sl == LW'(1) && d0) begin
				f = f;
			end else if (sl == LW'(2) && d0 && d1) begin
				if (l == '0 || (l == LW'(1) && rt))
					f = 1'b1;
				else
					poprq = 1'b1;
			end else if (sl > CAP_L) begin
				f = 1'b1;
			end else begin
				sneed = (l != '0) && !(l == LW'(1) && rt);
				need  = PW'(l) + PW'(sneed) + PW'(sl);
				if (need > CAP_P) begin
					f = 1'b1;
				end else begin
					l = need[LW-1:0];
					// separator laid down ahead of the next segment
					if (sep && need < CAP_P) begin
						we    = 1'b1;
						waddr = need[AW-1:0];
						wdata = CH_SLASH;
					end
				end
			end
		end
		if (sep) begin
			sl = '0;
			nf = 1'b0;
		end
		if (end_of_string) begin
			if (ph == PH_BASE) begin
				sl = '0;
				nf = 1'b0;
				ph = PH_REL;
				fr = 1'b1;
			end else begin
				emrq = 1'b1;
				ph   = PH_IDLE;
			end
		end
	end

	logic [LW-1:0] pop_lo;
	logic          rd_en;
	logic [AW-1:0] raddr;

	assign pop_lo = root_q ? LW'(1) : LW'(0);

	assign st.pop_req   = poprq;
	assign st.emit_req  = emrq;
	assign st.pop_end   = (pop_ptr_q == pop_lo);
	assign st.pop_hit   = (rdata_q == CH_SLASH);
	assign st.out_free  = !ovalid_q || out_ready;
	assign st.reject    = fail_q || (len_q == '0);
	assign st.last_byte = (LW'(e_idx_q) == len_q - LW'(1));

	assign rd_en = (cmd.pop_rd && !st.pop_end) || (cmd.emit_rd && st.out_free && !st.reject);
	assign raddr = cmd.pop_rd ? AW'(pop_ptr_q - LW'(1)) : e_idx_q;

	always_ff @(posedge clk) begin
		if (cmd.take && we)
			mem[waddr] <= wdata;
		if (rd_en)
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			dot0_q    <= d0;
			dot1_q    <= d1;
			pop_ptr_q <= l;
			e_idx_q   <= '0;
		end
		if (cmd.pop_chk && !st.pop_hit)
			pop_ptr_q <= pop_ptr_q - LW'(1);
		if (cmd.emit_ld)
			e_idx_q <= e_idx_q + AW'(1);
		if (cmd.emit_rd && st.out_free && st.reject) begin
			ostat_q <= 1'b1;
			ochar_q <= CH_NUL;
			olast_q <= 1'b1;
		end
		if (cmd.emit_ld) begin
			ostat_q <= 1'b0;
			ochar_q <= rdata_q;
			olast_q <= st.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jphase_q <= PH_IDLE;
			len_q    <= '0;
			seglen_q <= '0;
			fail_q   <= 1'b0;
			nul_q    <= 1'b0;
			fresh_q  <= 1'b1;
			root_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				jphase_q <= ph;
				len_q    <= l;
				seglen_q <= sl;
				fail_q   <= f;
				nul_q    <= nf;
				fresh_q  <= fr;
				root_q   <= rt;
			end
			if (cmd.pop_rd && st.pop_end)
				len_q <= pop_lo;
			if (cmd.pop_chk && st.pop_hit)
				len_q <= pop_ptr_q - LW'(1);
			if ((cmd.emit_rd && st.out_free && st.reject) || cmd.emit_ld)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	assign out_valid = ovalid_q;
	assign status    = ostat_q;
	assign char_out  = ochar_q;
	assign final_res = olast_q;

endmodule

// ----- design/path_normalizer_core.sv -----
// input: one path byte per cycle while a job streams in, unless a scan or a result burst holds it off
// a ".." segment scans back to the previous separator, each byte read and then checked
// result burst: each output byte is read from the store, then loaded into the output register;
// a rejection is 1 transaction; input held off meanwhile
// the burst starts after the last input transaction of a job and after any scan
// reset arst_n clears all control state; the byte store needs no clearing pass
module path_normalizer_core import pn_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	// input stream
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // char_in
	input  logic [2:0] s_axis_tuser,  // op[1:0], no_char[2]
	input  logic       s_axis_tlast,  // end_of_string
	// result stream
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // char_out
	output logic       m_axis_tuser,  // status
	output logic       m_axis_tlast   // final_res
);

	pn_cmd_t  cmd;
	pn_stat_t st;

	// sequencing: accept, backward scan, burst readout
	pn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// byte store, segment tracking and output register
	pn_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.op            (s_axis_tuser[1:0]),
		.char_in       (s_axis_tdata),
		.no_char       (s_axis_tuser[2]),
		.end_of_string (s_axis_tlast),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.status        (m_axis_tuser),
		.char_out      (m_axis_tdata),
		.final_res     (m_axis_tlast)
	);

	// a rejection is a single transaction carrying a zero byte
	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == CH_NUL))
		else $error("rejection transaction malformed");

	// end of a lone or relative string stops input until the result has gone into the output register
	a_hold_after_eos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take && st.emit_req |=> !s_axis_tready)
		else $error("input accepted during result burst");

	// a pop scan never runs with input open
	a_pop_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop_rd || cmd.pop_chk) |-> !s_axis_tready)
		else $error("input open during scan");

endmodule

// ----- sim/path_normalizer_checker.sv -----
`timescale 1ns / 100ps

module path_normalizer_checker import pn_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	input  logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,
	input  logic [2:0] s_axis_tuser,
	input  logic       s_axis_tlast,
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata,
	input  logic       m_axis_tuser,
	input  logic       m_axis_tlast,
	output int         fail_count,
	output int         pending
);

	localparam logic ST_OK     = 1'b0;
	localparam logic ST_REJECT = 1'b1;

	typedef struct packed {
		logic       status;
		logic [7:0] ch;
		logic       last;
	} norm_byte_t;

	norm_byte_t norm_q[$];

	// shadow state of the normalizer
	logic [7:0] path_buf[CAPACITY];
	int         path_len;
	logic [7:0] seg_buf[CAPACITY];
	int         seg_len;
	logic [1:0] role;
	logic       job_fail;
	logic       seg_nul;
	logic       fresh;

	function automatic logic root_only();
		return path_len == 1 && path_buf[0] == CH_SLASH;
	endfunction

	task automatic drop_last_segment();
		int start;
		if (path_len == 0 || root_only()) begin
			job_fail = 1'b1;
			return;
		end
		start = (path_buf[0] == CH_SLASH) ? 1 : 0;
		for (int i = start; i < path_len; i++)
			if (path_buf[i] == CH_SLASH)
				start = i;
		path_len = start;
	endtask

	task automatic close_segment();
		int sep;
		if (job_fail || seg_len == 0)
			return;
		if (seg_len == 1 && seg_buf[0] == CH_DOT)
			return;
		if (seg_len == 2 && seg_buf[0] == CH_DOT && seg_buf[1] == CH_DOT) begin
			drop_last_segment();
			return;
		end
		if (seg_len > CAPACITY) begin
			job_fail = 1'b1;
			return;
		end
		sep = (path_len != 0 && !root_only()) ? 1 : 0;
		if (path_len > CAPACITY || seg_len + sep > CAPACITY - path_len) begin
			job_fail = 1'b1;
			return;
		end
		if (sep)
			path_buf[path_len++] = CH_SLASH;
		for (int i = 0; i < seg_len; i++)
			path_buf[path_len++] = seg_buf[i];
	endtask

	task automatic absorb_byte(input logic [7:0] ch);
		logic is_sep;
		is_sep = (ch == CH_SLASH || ch == CH_BSLASH);
		if (fresh) begin
			fresh = 1'b0;
			if (is_sep) begin
				path_buf[0] = CH_SLASH;
				path_len = 1;
				if (role == PH_REL)
					job_fail = 1'b0;
			end
		end
		if (role != PH_BASE && ch == CH_NUL)
			job_fail = 1'b1;
		if (is_sep) begin
			if (role == PH_BASE && seg_nul)
				job_fail = 1'b1;
			close_segment();
			seg_len = 0;
			seg_nul = 1'b0;
			return;
		end
		if (ch == CH_NUL)
			seg_nul = 1'b1;
		if (seg_len < CAPACITY)
			seg_buf[seg_len++] = ch;
		else
			seg_len = CAPACITY + 1;
	endtask

	task automatic normalize_step(input logic [1:0] op, input logic [7:0] ch,
		input logic no_char, input logic eos);
		if (role == PH_IDLE) begin
			role = (op == OP_LONE) ? PH_LONE : (op == OP_BASE) ? PH_BASE : PH_REL;
			fresh = 1'b1;
			path_len = 0;
			job_fail = 1'b0;
			seg_len = 0;
			seg_nul = 1'b0;
		end
		if (!no_char)
			absorb_byte(ch);
		if (!eos)
			return;
		if (role == PH_BASE) begin
			// base done, relative path follows
			seg_len = 0;
			seg_nul = 1'b0;
			role = PH_REL;
			fresh = 1'b1;
			return;
		end
		close_segment();
		if (job_fail || path_len == 0 || path_len > CAPACITY)
			norm_q.push_back('{ST_REJECT, 8'h00, 1'b1});
		else
			for (int i = 0; i < path_len; i++)
				norm_q.push_back('{ST_OK, path_buf[i], i == path_len - 1});
		role = PH_IDLE;
		path_len = 0;
		job_fail = 1'b0;
		fresh = 1'b1;
		seg_len = 0;
		seg_nul = 1'b0;
	endtask

	initial begin
		fail_count = 0;
		path_len = 0;
		seg_len = 0;
		role = PH_IDLE;
		job_fail = 1'b0;
		seg_nul = 1'b0;
		fresh = 1'b1;
	end

	assign pending = norm_q.size();

	always @(posedge clk) begin
		norm_byte_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				normalize_step(s_axis_tuser[1:0], s_axis_tdata, s_axis_tuser[2],
					s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				if (norm_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: status %0d byte %02h last %0d",
							m_axis_tuser, m_axis_tdata, m_axis_tlast);
				end else begin
					want = norm_q.pop_front();
					if (want.status !== m_axis_tuser || want.ch !== m_axis_tdata ||
						want.last !== m_axis_tlast) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %0d/%02h/%0d got %0d/%02h/%0d",
								want.status, want.ch, want.last,
								m_axis_tuser, m_axis_tdata, m_axis_tlast);
					end
				end
			end
		end
	end

endmodule

// ----- sim/path_normalizer_core_tb.sv -----
`timescale 1ns / 100ps

module path_normalizer_core_tb import pn_pkg::*;;

	localparam int         IDLE_LIMIT = 3000;
	localparam int         LONG_HOLD  = 300;
	localparam logic [1:0] OP_REL     = 2'd2;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic [2:0] s_axis_tuser;
	logic       s_axis_tlast;
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tuser;
	logic       m_axis_tlast;

	int   fail_count;
	int   pending;
	int   items_sent;
	int   results_seen;
	int   idle_cycles;
	logic no_idle;
	logic hold_done;

	path_normalizer_core u_top (.*);

	path_normalizer_checker u_chk (.*);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// mostly back to back, some short gaps, rare long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// one input transaction; entered and left at a falling edge
	task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
		input logic no_char, input logic eos);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tuser  <= {no_char, op};
		s_axis_tlast  <= eos;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		@(negedge clk);
	endtask

	// a whole string; first item carries the job op, the rest random op bits
	task automatic send_bytes(input logic [1:0] op, input logic [7:0] q[$]);
		if (q.size() == 0) begin
			send_item(op, 8'($urandom), 1'b1, 1'b1);
			return;
		end
		for (int i = 0; i < q.size(); i++) begin
			if (i > 0 && $urandom_range(0, 19) == 0)
				send_item(2'($urandom), 8'($urandom), 1'b1, 1'b0);
			send_item(i == 0 ? op : 2'($urandom), q[i], 1'b0, i == q.size() - 1);
		end
	endtask

	// directed strings: '%' stands for a nul byte
	task automatic send_text(input logic [1:0] op, input string s);
		logic [7:0] q[$];
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i] == "%" ? CH_NUL : s[i]);
		send_bytes(op, q);
	endtask

	// random path built from segments, mostly well formed
	task automatic build_path(output logic [7:0] q[$], input logic with_file);
		int nseg;
		int r;
		int n;
		q = {};
		if ($urandom_range(0, 9) < 3)
			q.push_back($urandom_range(0, 1) ? CH_SLASH : CH_BSLASH);
		nseg = $urandom_range(0, 6);
		for (int s = 0; s < nseg; s++) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
			end else if (r < 30)
				q.push_back(CH_DOT);
			else if (r < 45) begin
				q.push_back(CH_DOT);
				q.push_back(CH_DOT);
			end else if (r < 88) begin
				n = $urandom_range(1, 8);
				repeat (n) q.push_back($urandom_range(0, 5) == 0 ? CH_DOT :
					8'($urandom_range(8'h61, 8'h7a)));
			end else if (r < 94) begin
				n = $urandom_range(1, 4);
				repeat (n) q.push_back(8'($urandom));
			end else if (r < 97) begin
				q.push_back(8'h61);
				q.push_back(CH_NUL);
			end else begin
				n = $urandom_range(30, 70);
				repeat (n) q.push_back(8'($urandom_range(8'h41, 8'h5a)));
			end
			if (s < nseg - 1 || $urandom_range(0, 4) == 0)
				q.push_back($urandom_range(0, 1) ? CH_SLASH : CH_BSLASH);
		end
		if (with_file) begin
			// trailing file name, sometimes with a nul or overlong
			r = $urandom_range(0, 9);
			n = (r == 0) ? $urandom_range(65, 80) : $urandom_range(0, 6);
			repeat (n) q.push_back(8'($urandom_range(8'h30, 8'h39)));
			if (r == 1)
				q.push_back(CH_NUL);
		end
	endtask

	// receiver: random stalls plus one long hold-off to back up the block
	initial begin
		m_axis_tready = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= 40) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				int gap;
				gap = pick_gap();
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			results_seen++;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			!arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [7:0] base_q[$];
		logic [7:0] rel_q[$];
		int         mode;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		s_axis_tuser = 3'b000;
		s_axis_tlast = 1'b0;
		items_sent = 0;
		results_seen = 0;
		idle_cycles = 0;
		no_idle = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: root only, unmatched parent, empty, nul, empty result
		send_text(OP_LONE, "/");
		send_text(OP_LONE, "a/../..");
		send_text(OP_LONE, "");
		send_text(OP_LONE, "b%");
		send_text(OP_LONE, "./.");
		send_bytes(OP_LONE, '{8'hff, CH_BSLASH, 8'h80});
		// joins: plain, rooted relative, nul in base file name, empty base op 3
		send_text(OP_BASE, "/x/f");
		send_text(OP_REL, "y");
		send_text(OP_BASE, "d%/f");
		send_text(OP_REL, "\\g");
		send_text(OP_BASE, "d/f%");
		send_text(OP_REL, "g");
		send_text(2'd3, "h\\..\\k");

		while (items_sent < 200) begin
			no_idle = ($urandom_range(0, 5) == 0);
			mode = $urandom_range(0, 9);
			if (mode < 4) begin
				build_path(rel_q, 1'b0);
				send_bytes(OP_LONE, rel_q);
			end else if (mode < 9) begin
				build_path(base_q, 1'b1);
				build_path(rel_q, 1'b0);
				send_bytes(OP_BASE, base_q);
				send_bytes(2'($urandom), rel_q);
			end else begin
				build_path(rel_q, 1'b0);
				send_bytes($urandom_range(0, 1) ? OP_REL : 2'd3, rel_q);
			end
		end
		s_axis_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
